// ----- hdl/vmm_pkg.sv -----
`timescale 1ns / 1ps

package vmm_pkg;

  // field and register widths
  localparam int CELL_W       = 10;
  localparam int DIST_BITS_D  = 16;
  localparam int GRID_SIDE_D  = 1024;
  localparam int ORG_W        = 32;
  localparam int VOX_W        = 31;
  localparam int MASS_W       = 31;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int ACC_W        = 64;
  localparam int NUM_OUT      = 10;
  localparam int OUT_W        = NUM_OUT * ACC_W;
  localparam int QUEUE_DEPTH  = 2;

  // centre and multiplier datapath widths
  localparam int PROD_W       = VOX_W + CELL_W + 1;
  localparam int CTR_W        = PROD_W + 2;
  localparam int MAG_W        = CTR_W - 1;
  localparam int A_W          = MAG_W + MASS_W;
  localparam int DIGIT_W      = 8;
  localparam int DIGITS       = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int B_W          = DIGITS * DIGIT_W;
  localparam int P_W          = 2 * MAG_W + MASS_W + 1;
  localparam int DIGIT_CNT_W  = $clog2(DIGITS);

  // rounding of a magnitude down to Q32.32
  localparam int SHIFT_FIRST  = 1;
  localparam int SHIFT_QUAD   = 18;

  // sequencing of multiply terms and jobs
  localparam int NUM_TERMS    = 12;
  localparam int NUM_JOBS     = 9;
  localparam int TERM_W       = 4;
  localparam int JOB_W        = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [VOX_W-1:0]  VOX_RESET  = 31'd65536;
  localparam logic [MASS_W-1:0] MASS_RESET = 31'd65536000;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_VOXEL_X   = 3'd3,
    CFG_VOXEL_Y   = 3'd4,
    CFG_VOXEL_Z   = 3'd5,
    CFG_CELL_MASS = 3'd6
  } vmm_cfg_idx_e;

  typedef struct packed {
    logic [2:0][ORG_W-1:0] origin;
    logic [2:0][VOX_W-1:0] voxel;
    logic [MASS_W-1:0]     mass;
  } vmm_cfg_t;

  // one classified cell in the queue
  typedef struct packed {
    logic                   last;
    logic                   solid;
    logic [2:0][CELL_W-1:0] cell_idx;
  } vmm_entry_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
  } vmm_mul_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_ABS,
    ST_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_ACC,
    ST_EMIT
  } vmm_state_e;

  typedef enum logic [1:0] {
    ASEL_MASS,
    ASEL_FM_X,
    ASEL_FM_Y,
    ASEL_FM_Z
  } vmm_asel_e;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_DIAG,
    KIND_PROD
  } vmm_kind_e;

  typedef struct packed {
    vmm_asel_e  a_sel;
    logic [1:0] b_axis;
    logic       job_first;
    logic       job_end;
  } vmm_term_t;

  typedef struct packed {
    vmm_kind_e  kind;
    logic [1:0] ax0;
    logic [1:0] ax1;
  } vmm_job_t;

  // operands of each multiply term; fm is mass times |centre| of an axis
  function automatic vmm_term_t term_info(input logic [TERM_W-1:0] t);
    vmm_term_t r;
    case (t)
      4'd0:    r = '{ASEL_MASS, AXIS_X, 1'b1, 1'b1};
      4'd1:    r = '{ASEL_MASS, AXIS_Y, 1'b1, 1'b1};
      4'd2:    r = '{ASEL_MASS, AXIS_Z, 1'b1, 1'b1};
      4'd3:    r = '{ASEL_FM_Y, AXIS_Y, 1'b1, 1'b0};
      4'd4:    r = '{ASEL_FM_Z, AXIS_Z, 1'b0, 1'b1};
      4'd5:    r = '{ASEL_FM_X, AXIS_X, 1'b1, 1'b0};
      4'd6:    r = '{ASEL_FM_Z, AXIS_Z, 1'b0, 1'b1};
      4'd7:    r = '{ASEL_FM_X, AXIS_X, 1'b1, 1'b0};
      4'd8:    r = '{ASEL_FM_Y, AXIS_Y, 1'b0, 1'b1};
      4'd9:    r = '{ASEL_FM_X, AXIS_Y, 1'b1, 1'b1};
      4'd10:   r = '{ASEL_FM_X, AXIS_Z, 1'b1, 1'b1};
      4'd11:   r = '{ASEL_FM_Y, AXIS_Z, 1'b1, 1'b1};
      default: r = '{ASEL_MASS, AXIS_X, 1'b1, 1'b1};
    endcase
    return r;
  endfunction

  // job j lands in output slot j+1
  function automatic vmm_job_t job_info(input logic [JOB_W-1:0] j);
    vmm_job_t r;
    case (j)
      4'd0:    r = '{KIND_FIRST, AXIS_X, AXIS_X};
      4'd1:    r = '{KIND_FIRST, AXIS_Y, AXIS_Y};
      4'd2:    r = '{KIND_FIRST, AXIS_Z, AXIS_Z};
      4'd3:    r = '{KIND_DIAG,  AXIS_X, AXIS_X};
      4'd4:    r = '{KIND_DIAG,  AXIS_Y, AXIS_Y};
      4'd5:    r = '{KIND_DIAG,  AXIS_Z, AXIS_Z};
      4'd6:    r = '{KIND_PROD,  AXIS_X, AXIS_Y};
      4'd7:    r = '{KIND_PROD,  AXIS_X, AXIS_Z};
      4'd8:    r = '{KIND_PROD,  AXIS_Y, AXIS_Z};
      default: r = '{KIND_DIAG,  AXIS_X, AXIS_X};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/vmm_fifo.sv -----
`timescale 1ns / 1ps

module vmm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q, mem_d;
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  // memory, pointer and count update
  always_comb begin
    mem_d = mem_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      mem_d[wr_q] = push_data_i;
      wr_d        = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_q <= mem_d;
  end

endmodule

// ----- hdl/vmm_front.sv -----
`timescale 1ns / 1ps

module vmm_front import vmm_pkg::*; #(
  parameter int DIST_BITS = DIST_BITS_D,
  parameter int GRID_SIDE = GRID_SIDE_D
) (
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [3*CELL_W+8*DIST_BITS-1:0]        in_fields_i,
  input  logic                                   in_last_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output vmm_entry_t                             q_entry_o
);

  localparam int SUM_W = DIST_BITS + 3;
  localparam int LIM_W = 17;
  localparam logic [LIM_W-1:0] GridLimit = LIM_W'(GRID_SIDE - 1);

  logic [2:0][CELL_W-1:0] cell_idx;
  logic [SUM_W-1:0]       sum;
  logic [DIST_BITS-1:0]   corner;
  logic                   in_grid;

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // cell indices and the existence check
  always_comb begin
    in_grid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      cell_idx[a] = in_fields_i[a*CELL_W +: CELL_W];
      if (LIM_W'(cell_idx[a]) >= GridLimit) begin
        in_grid = 1'b0;
      end
    end
  end

  // sum of the eight corner distances
  always_comb begin
    sum    = '0;
    corner = '0;
    for (int k = 0; k < 8; k++) begin
      corner = in_fields_i[3*CELL_W + k*DIST_BITS +: DIST_BITS];
      sum    = sum + {{3{corner[DIST_BITS-1]}}, corner};
    end
  end

  assign q_entry_o.cell_idx = cell_idx;
  assign q_entry_o.solid    = in_grid & sum[SUM_W-1];
  assign q_entry_o.last     = in_last_i;

endmodule

// ----- hdl/vmm_mul.sv -----
`timescale 1ns / 1ps

module vmm_mul import vmm_pkg::*; (
  input  logic           clk_i,
  input  vmm_mul_ctrl_t  ctrl_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic [P_W-1:0] p_o
);

  localparam int ASH_W = A_W + B_W - DIGIT_W;
  localparam int PP_W  = ASH_W + DIGIT_W;

  logic [ASH_W-1:0] a_sh_q, a_sh_d;
  logic [B_W-1:0]   b_sh_q, b_sh_d;
  logic [P_W-1:0]   p_q, p_d;
  logic [PP_W-1:0]  pp;

  // one 8-bit digit of b per step, least significant first
  assign pp = PP_W'(a_sh_q) * PP_W'(b_sh_q[DIGIT_W-1:0]);

  always_comb begin
    a_sh_d = a_sh_q;
    b_sh_d = b_sh_q;
    p_d    = p_q;
    if (ctrl_i.load) begin
      a_sh_d = ASH_W'(a_i);
      b_sh_d = b_i;
      if (ctrl_i.clear) begin
        p_d = '0;
      end
    end else if (ctrl_i.step) begin
      a_sh_d = a_sh_q << DIGIT_W;
      b_sh_d = b_sh_q >> DIGIT_W;
      p_d    = p_q + pp[P_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    a_sh_q <= a_sh_d;
    b_sh_q <= b_sh_d;
    p_q    <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- hdl/vmm_back.sv -----
`timescale 1ns / 1ps

module vmm_back import vmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vmm_cfg_t         cfg_i,
  input  logic             q_valid_i,
  input  vmm_entry_t       q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  localparam logic [P_W:0] HalfFirst = (P_W+1)'(1) << (SHIFT_FIRST - 1);
  localparam logic [P_W:0] HalfQuad  = (P_W+1)'(1) << (SHIFT_QUAD - 1);
  localparam logic [DIGIT_CNT_W-1:0] DigitLast = DIGIT_CNT_W'(DIGITS - 1);
  localparam logic [JOB_W-1:0]       JobLast   = JOB_W'(NUM_JOBS - 1);

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W+1:0] s);
    if (s[ACC_W+1] == s[ACC_W] && s[ACC_W] == s[ACC_W-1]) begin
      return s[ACC_W-1:0];
    end
    return s[ACC_W+1] ? ACC_MIN : ACC_MAX;
  endfunction

  vmm_state_e state_q, state_d;

  logic [2:0][CELL_W-1:0]        idx_q, idx_d;
  logic                          last_q, last_d;
  logic [2:0][CTR_W-1:0]         c_q, c_d;
  logic [2:0][MAG_W-1:0]         mag_q, mag_d;
  logic [2:0]                    neg_q, neg_d;
  logic [2:0][A_W-1:0]           fm_q, fm_d;
  logic [TERM_W-1:0]             term_q, term_d;
  logic [JOB_W-1:0]              job_q, job_d;
  logic [DIGIT_CNT_W-1:0]        digit_q, digit_d;
  logic [ACC_W-1:0]              qc_q, qc_d;
  logic                          qneg_q, qneg_d;
  logic [NUM_OUT-1:0][ACC_W-1:0] acc_q, acc_d;
  logic                          out_valid_q, out_valid_d;
  logic [OUT_W-1:0]              out_data_q, out_data_d;

  vmm_term_t             term;
  vmm_job_t              job;
  vmm_mul_ctrl_t         mul_ctrl;
  logic [A_W-1:0]        mul_a;
  logic [P_W-1:0]        mul_p;
  logic [2:0][PROD_W-1:0] scale;
  logic [2:0][CTR_W-1:0] centre;
  logic [2:0][CTR_W-1:0] c_abs;
  logic [P_W:0]          rnd_sum, rnd_shift;
  logic                  rnd_first, rnd_ovf, rnd_neg;
  logic [ACC_W-1:0]      rnd_q;
  logic [JOB_W-1:0]      dest;
  logic [ACC_W-1:0]      acc_cur;
  logic [ACC_W+1:0]      acc_sum, mass_sum;

  assign term = term_info(term_q);
  assign job  = job_info(job_q);

  // centre in units of 2^-17: 2*origin + voxel*(2*index+1)
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      scale[a]  = PROD_W'(cfg_i.voxel[a]) * PROD_W'({idx_q[a], 1'b1});
      centre[a] = {{(CTR_W-ORG_W-1){cfg_i.origin[a][ORG_W-1]}}, cfg_i.origin[a], 1'b0}
                + {2'b00, scale[a]};
      c_abs[a]  = c_q[a][CTR_W-1] ? (~c_q[a] + 1'b1) : c_q[a];
    end
  end

  // multiplicand for the current term
  always_comb begin
    case (term.a_sel)
      ASEL_MASS: mul_a = A_W'(cfg_i.mass);
      ASEL_FM_X: mul_a = fm_q[AXIS_X];
      ASEL_FM_Y: mul_a = fm_q[AXIS_Y];
      ASEL_FM_Z: mul_a = fm_q[AXIS_Z];
      default:   mul_a = A_W'(cfg_i.mass);
    endcase
  end

  vmm_mul u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (B_W'(mag_q[term.b_axis])),
    .p_o    (mul_p)
  );

  // round to nearest, ties away from zero, then clamp the magnitude
  assign rnd_first = (job.kind == KIND_FIRST);
  assign rnd_sum   = {1'b0, mul_p} + (rnd_first ? HalfFirst : HalfQuad);
  assign rnd_shift = rnd_first ? (rnd_sum >> SHIFT_FIRST) : (rnd_sum >> SHIFT_QUAD);
  assign rnd_ovf   = |rnd_shift[P_W:ACC_W-1];

  always_comb begin
    case (job.kind)
      KIND_FIRST: rnd_neg = neg_q[job.ax0];
      KIND_PROD:  rnd_neg = (neg_q[job.ax0] == neg_q[job.ax1]);
      default:    rnd_neg = 1'b0;
    endcase
  end

  assign rnd_q = rnd_ovf ? (rnd_neg ? ACC_MIN : ACC_MAX)
                         : {1'b0, rnd_shift[ACC_W-2:0]};

  // saturating accumulate into the slot of the current job
  assign dest     = job_q + 1'b1;
  assign acc_cur  = acc_q[dest];
  assign acc_sum  = qneg_q ? ({{2{acc_cur[ACC_W-1]}}, acc_cur} - {2'b00, qc_q})
                           : ({{2{acc_cur[ACC_W-1]}}, acc_cur} + {2'b00, qc_q});
  assign mass_sum = {{2{acc_q[0][ACC_W-1]}}, acc_q[0]}
                  + (ACC_W+2)'({cfg_i.mass, 16'd0});

  // sequencer
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    mul_ctrl    = '0;
    idx_d       = idx_q;
    last_d      = last_q;
    c_d         = c_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    fm_d        = fm_q;
    term_d      = term_q;
    job_d       = job_q;
    digit_d     = digit_q;
    qc_d        = qc_q;
    qneg_d      = qneg_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          idx_d   = q_entry_i.cell_idx;
          last_d  = q_entry_i.last;
          if (q_entry_i.solid) begin
            state_d = ST_CENTRE;
          end else if (q_entry_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CENTRE: begin
        c_d      = centre;
        acc_d[0] = sat_acc(mass_sum);
        state_d  = ST_ABS;
      end
      ST_ABS: begin
        for (int a = 0; a < 3; a++) begin
          mag_d[a] = c_abs[a][MAG_W-1:0];
          neg_d[a] = c_q[a][CTR_W-1];
        end
        term_d  = '0;
        job_d   = '0;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        mul_ctrl.load  = 1'b1;
        mul_ctrl.clear = term.job_first;
        digit_d        = '0;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        digit_d       = digit_q + 1'b1;
        if (digit_q == DigitLast) begin
          if (term.job_end) begin
            state_d = ST_ROUND;
          end else begin
            term_d  = term_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_ROUND: begin
        qc_d   = rnd_q;
        qneg_d = rnd_neg;
        if (rnd_first) begin
          fm_d[job.ax0] = mul_p[A_W-1:0];
        end
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d[dest] = sat_acc(acc_sum);
        term_d      = term_q + 1'b1;
        job_d       = job_q + 1'b1;
        if (job_q == JobLast) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = acc_q;
          out_valid_d = 1'b1;
          acc_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      term_q      <= '0;
      job_q       <= '0;
      digit_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      term_q      <= term_d;
      job_q       <= job_d;
      digit_q     <= digit_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    c_q        <= c_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    fm_q       <= fm_d;
    qc_q       <= qc_d;
    qneg_q     <= qneg_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/voxel_mass_moment_accumulator_core.sv -----
`timescale 1ns / 1ps
// channel   direction  ports                          beat
// s_axis    in         tvalid/tready/tdata/tlast      one grid cell, tlast = last cell
// m_axis    out        tvalid/tready/tdata            ten Q32.32 totals of one run
// cfg       in         cfg_we_i/cfg_idx_i/cfg_data_i  one register write, no stall
//
// The front end takes a cell per cycle while its two-entry queue has room.
// The back end drops an empty or out-of-grid cell from its idle state; a
// solid one runs twelve 74x43 multiply terms, b taken in six 8-bit digits
// on one shared digit multiplier, plus centre, rounding and accumulate steps.
// A last cell then moves the totals to the output register.
// Reset loads the register defaults and zeroes the sums; no clearing pass.

module voxel_mass_moment_accumulator_core import vmm_pkg::*; #(
  parameter int DIST_BITS = DIST_BITS_D,
  parameter int GRID_SIDE = GRID_SIDE_D
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // cell_x, cell_y, cell_z, corner_000, corner_100, corner_010, corner_110,
  // corner_001, corner_101, corner_011, corner_111, zero fill
  input  logic [((3*CELL_W+8*DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // total_mass, moment_x, moment_y, moment_z, inertia_xx, inertia_yy,
  // inertia_zz, product_xy, product_xz, product_yz
  output logic [OUT_W-1:0]     m_axis_tdata
);

  localparam int FIELD_W = 3*CELL_W + 8*DIST_BITS;
  localparam int ENTRY_W = $bits(vmm_entry_t);

  vmm_cfg_t   cfg_q, cfg_d;
  vmm_entry_t push_entry, pop_entry;
  logic       q_full, q_push, q_pop, q_valid;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (vmm_cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:  cfg_d.origin[AXIS_X] = cfg_data_i;
        CFG_ORIGIN_Y:  cfg_d.origin[AXIS_Y] = cfg_data_i;
        CFG_ORIGIN_Z:  cfg_d.origin[AXIS_Z] = cfg_data_i;
        CFG_VOXEL_X:   cfg_d.voxel[AXIS_X]  = cfg_data_i[VOX_W-1:0];
        CFG_VOXEL_Y:   cfg_d.voxel[AXIS_Y]  = cfg_data_i[VOX_W-1:0];
        CFG_VOXEL_Z:   cfg_d.voxel[AXIS_Z]  = cfg_data_i[VOX_W-1:0];
        CFG_CELL_MASS: cfg_d.mass           = cfg_data_i[MASS_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      cfg_q.voxel  <= {VOX_RESET, VOX_RESET, VOX_RESET};
      cfg_q.mass   <= MASS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify incoming cells
  vmm_front #(
    .DIST_BITS (DIST_BITS),
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_fields_i (s_axis_tdata[FIELD_W-1:0]),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  // queue between classification and accumulation
  vmm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_entry),
    .valid_o     (q_valid)
  );

  // centre, products and saturating sums
  vmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- bench/tb_voxel_mass_moment_accumulator_core.sv -----
`timescale 1ns / 1ps

module tb_voxel_mass_moment_accumulator_core;
  import vmm_pkg::*;

  localparam int CORNERS_W   = 8 * DIST_BITS_D;
  localparam int CELL_BEAT_W = ((3 * CELL_W + CORNERS_W + 7) / 8) * 8;
  localparam int FILL_W      = CELL_BEAT_W - 3 * CELL_W - CORNERS_W;
  localparam int NUM_REGS    = int'(CFG_CELL_MASS) + 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 120;
  localparam int MAX_GAP     = 13;
  localparam int CELLS_PER_SETTING = 140;
  localparam int NUM_PHASES  = 8;
  localparam logic [31:0] TOP31 = 32'h7FFF_FFFF;

  // corner patterns for the directed cells
  localparam logic [CORNERS_W-1:0] CRN_ZERO      = '0;
  localparam logic [CORNERS_W-1:0] CRN_ALL_NEG1  = {8{16'hFFFF}};
  localparam logic [CORNERS_W-1:0] CRN_ONE_NEG1  = {{7{16'h0000}}, 16'hFFFF};
  localparam logic [CORNERS_W-1:0] CRN_ONE_POS1  = {{7{16'h0000}}, 16'h0001};
  localparam logic [CORNERS_W-1:0] CRN_ZERO_MIX  = {4{16'h0001, 16'hFFFF}};
  localparam logic [CORNERS_W-1:0] CRN_ALL_MAX   = {8{16'h7FFF}};
  localparam logic [CORNERS_W-1:0] CRN_ALL_MIN   = {8{16'h8000}};
  localparam logic [CORNERS_W-1:0] CRN_HALF_MIX  = {4{16'h7FFF, 16'h8000}};
  localparam logic [CORNERS_W-1:0] CRN_SEVEN_MAX = {{7{16'h7FFF}}, 16'h8000};
  localparam logic [CORNERS_W-1:0] CRN_SCATTER   = {16'h1234, 16'hEDCB, 16'h8001, 16'h7FFE,
                                                    16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA};

  typedef enum int {
    SET_WIDE,
    SET_MODERATE,
    SET_TOP,
    SET_BOTTOM,
    SET_SPLIT_SIGN,
    SET_TIES
  } setting_e;

  localparam int NUM_SETTINGS = int'(SET_TIES) + 1;

  typedef struct packed {
    logic [CELL_BEAT_W-1:0] beat;
    logic                   last;
    logic                   typed;
    logic [OUT_W-1:0]       totals;
  } cell_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_ORIGIN_X;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CELL_BEAT_W-1:0] s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;

  // register mirror and running sums of the predictor
  logic [2:0][ORG_W-1:0]  org_cfg = '0;
  logic [2:0][VOX_W-1:0]  vox_cfg = {3{VOX_RESET}};
  logic [MASS_W-1:0]      mass_cfg = MASS_RESET;
  logic [ACC_W-1:0]       mass_sum = '0;
  logic [2:0][ACC_W-1:0]  first_sum = '0;
  logic [2:0][ACC_W-1:0]  diag_sum = '0;
  logic [2:0][ACC_W-1:0]  prod_sum = '0;

  logic [OUT_W-1:0]       pending_totals [$];
  cell_row_t              cell_table [$];
  bit                     burst = 1'b0;
  int                     fail_cnt = 0;
  int                     cycle_cnt = 0;

  voxel_mass_moment_accumulator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // cell_x, cell_y, cell_z, corner_000 .. corner_111, zero fill
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // total_mass, moment_x/y/z, inertia_xx/yy/zz, product_xy/xz/yz
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [ACC_W-1:0] sat_sum(input logic [ACC_W-1:0] a,
                                              input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  // magnitude in units of 2^-(32+sh), rounded half away from zero, saturated
  function automatic logic [ACC_W-1:0] round_q32(input logic [127:0] mag, input bit neg,
                                                input int sh);
    logic [127:0] q;
    q = (mag + (128'd1 << (sh - 1))) >> sh;
    if (q[127:63] != '0) return neg ? ACC_MIN : ACC_MAX;
    return neg ? -q[63:0] : q[63:0];
  endfunction

  // adds one cell to the running sums; on the last cell hands out and clears them
  function automatic bit accumulate_cell(input logic [CELL_BEAT_W-1:0] beat, input bit is_last,
                                         output logic [OUT_W-1:0] totals);
    logic [2:0][CELL_W-1:0] idx;
    logic signed [DIST_BITS_D-1:0] cv;
    logic signed [31:0] dsum;
    logic [63:0] o64, v64, n64, c;
    logic [2:0][127:0] mag;
    logic [2:0] neg;
    logic [127:0] m128, d, p;
    bit in_grid;
    int pa, pb;
    idx = beat[3*CELL_W-1:0];
    in_grid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (idx[a] >= GRID_SIDE_D - 1) in_grid = 1'b0;
    end
    dsum = 0;
    for (int k = 0; k < 8; k++) begin
      cv = beat[3*CELL_W + k*DIST_BITS_D +: DIST_BITS_D];
      dsum = dsum + cv;
    end
    totals = '0;

    // solid cell inside the grid
    if (in_grid && dsum < 0) begin
      m128 = {{(128-MASS_W){1'b0}}, mass_cfg};
      for (int a = 0; a < 3; a++) begin
        o64 = {{(64-ORG_W){org_cfg[a][ORG_W-1]}}, org_cfg[a]};
        v64 = {{(64-VOX_W){1'b0}}, vox_cfg[a]};
        n64 = {{(64-CELL_W-1){1'b0}}, idx[a], 1'b1};
        c = o64 + o64 + v64 * n64;
        neg[a] = c[63];
        mag[a] = {64'd0, (c[63] ? -c : c)};
      end
      mass_sum = sat_sum(mass_sum, {{(64-MASS_W-16){1'b0}}, mass_cfg, 16'd0});
      for (int a = 0; a < 3; a++) begin
        first_sum[a] = sat_sum(first_sum[a], round_q32(mag[a] * m128, neg[a], SHIFT_FIRST));
        d = mag[(a+1)%3] * mag[(a+1)%3] + mag[(a+2)%3] * mag[(a+2)%3];
        diag_sum[a] = sat_sum(diag_sum[a], round_q32(d * m128, 1'b0, SHIFT_QUAD));
        pa = (a == 2) ? 1 : 0;
        pb = (a == 0) ? 1 : 2;
        p = mag[pa] * mag[pb] * m128;
        prod_sum[a] = sat_sum(prod_sum[a],
                              round_q32(p, neg[pa] == neg[pb], SHIFT_QUAD));
      end
    end

    if (!is_last) return 1'b0;
    totals[0 +: ACC_W] = mass_sum;
    for (int a = 0; a < 3; a++) begin
      totals[(1+a)*ACC_W +: ACC_W] = first_sum[a];
      totals[(4+a)*ACC_W +: ACC_W] = diag_sum[a];
      totals[(7+a)*ACC_W +: ACC_W] = prod_sum[a];
    end
    mass_sum = '0;
    first_sum = '0;
    diag_sum = '0;
    prod_sum = '0;
    return 1'b1;
  endfunction

  // totals with whole-number values, symmetric over the three axes
  function automatic logic [OUT_W-1:0] whole_totals(input int m, input int fm, input int dg,
                                                   input int pr);
    logic [NUM_OUT-1:0][ACC_W-1:0] r;
    r[0] = {m, 32'd0};
    for (int a = 0; a < 3; a++) begin
      r[1+a] = {fm, 32'd0};
      r[4+a] = {dg, 32'd0};
      r[7+a] = {pr, 32'd0};
    end
    return r;
  endfunction

  function automatic logic [CELL_BEAT_W-1:0] pack_cell(input logic [2:0][CELL_W-1:0] idx,
                                                      input logic [CORNERS_W-1:0] corners);
    return {{FILL_W{1'b0}}, corners, idx};
  endfunction

  function automatic void add_row(input int x, input int y, input int z,
                                  input logic [CORNERS_W-1:0] corners, input bit is_last,
                                  input bit typed, input logic [OUT_W-1:0] totals);
    logic [2:0][CELL_W-1:0] idx;
    cell_row_t row;
    idx[0] = CELL_W'(x);
    idx[1] = CELL_W'(y);
    idx[2] = CELL_W'(z);
    row.beat = pack_cell(idx, corners);
    row.last = is_last;
    row.typed = typed;
    row.totals = totals;
    cell_table.insert(cell_table.size(), row);
  endfunction

  function automatic logic [CELL_BEAT_W-1:0] random_cell();
    logic [2:0][CELL_W-1:0] idx;
    logic [7:0][DIST_BITS_D-1:0] corner;
    int mode;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 31))
        0:       idx[a] = CELL_W'(GRID_SIDE_D - 1);
        1:       idx[a] = CELL_W'(GRID_SIDE_D - 2);
        2:       idx[a] = '0;
        default: idx[a] = CELL_W'($urandom_range(0, GRID_SIDE_D - 2));
      endcase
    end
    mode = $urandom_range(0, 3);
    for (int k = 0; k < 8; k++) begin
      case (mode)
        2:       corner[k] = DIST_BITS_D'($urandom_range(0, 15) - 8);
        3:       corner[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: corner[k] = DIST_BITS_D'($urandom());
      endcase
    end
    return pack_cell(idx, corner);
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [NUM_REGS-1:0][CFG_W-1:0] pick_setting(input setting_e kind);
    logic [NUM_REGS-1:0][CFG_W-1:0] r;
    logic [31:0] org, vox;
    org = '0;
    vox = 32'd1;
    for (int a = 0; a < 3; a++) begin
      case (kind)
        SET_WIDE:       begin org = $urandom(); vox = $urandom_range(1, TOP31); end
        SET_MODERATE:   begin
          org = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
          vox = $urandom_range(1, 32'h4000);
        end
        SET_TOP:        begin org = TOP31; vox = TOP31; end
        SET_BOTTOM:     begin org = 32'h8000_0000; vox = 32'd1; end
        SET_SPLIT_SIGN: begin org = 32'h8000_0000; vox = TOP31; end
        SET_TIES:       begin org = $urandom_range(0, 32'h1_FFFF) - 32'h1_0000; vox = 32'd1; end
        default:        begin org = '0; vox = 32'd1; end
      endcase
      r[int'(CFG_ORIGIN_X) + a] = org;
      r[int'(CFG_VOXEL_X) + a] = vox;
    end
    case (kind)
      SET_WIDE:       r[CFG_CELL_MASS] = $urandom_range(0, TOP31);
      SET_MODERATE:   r[CFG_CELL_MASS] = $urandom_range(0, 32'h10_0000);
      SET_TOP:        r[CFG_CELL_MASS] = TOP31;
      SET_BOTTOM:     r[CFG_CELL_MASS] = '0;
      SET_SPLIT_SIGN: r[CFG_CELL_MASS] = TOP31;
      SET_TIES:       r[CFG_CELL_MASS] = $urandom_range(0, 255) | 32'd1;
      default:        r[CFG_CELL_MASS] = '0;
    endcase
    return r;
  endfunction

  // one register per cycle, enable held high across the burst of writes
  task automatic apply_setting(input logic [NUM_REGS-1:0][CFG_W-1:0] vals);
    vmm_cfg_idx_e idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = vmm_cfg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (idx)
        CFG_ORIGIN_X:  org_cfg[0] = vals[i];
        CFG_ORIGIN_Y:  org_cfg[1] = vals[i];
        CFG_ORIGIN_Z:  org_cfg[2] = vals[i];
        CFG_VOXEL_X:   vox_cfg[0] = vals[i][VOX_W-1:0];
        CFG_VOXEL_Y:   vox_cfg[1] = vals[i][VOX_W-1:0];
        CFG_VOXEL_Z:   vox_cfg[2] = vals[i][VOX_W-1:0];
        CFG_CELL_MASS: mass_cfg = vals[i][MASS_W-1:0];
        default:       ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // valid stays high into the next cell when there is no gap
  task automatic send_cell(input logic [CELL_BEAT_W-1:0] beat, input bit is_last,
                           input int gap);
    logic [OUT_W-1:0] totals;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (accumulate_cell(beat, is_last, totals))
      pending_totals.insert(pending_totals.size(), totals);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_totals.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // runs of cells, each closed by a last cell
  task automatic run_phase(input int n_cells);
    int left, len;
    left = n_cells;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        send_cell(random_cell(), i == len - 1, draw_gap());
      end
      left -= len;
    end
  endtask

  // result side: random stalls, compare each totals beat
  initial begin : result_sink
    logic [OUT_W-1:0] want;
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      if (pending_totals.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("totals beat with none expected: %h", m_axis_tdata);
      end else begin
        want = pending_totals.pop_front();
        for (int f = 0; f < NUM_OUT; f++) begin
          if (m_axis_tdata[f*ACC_W +: ACC_W] !== want[f*ACC_W +: ACC_W]) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("field %0d mismatch: expected %h actual %h", f,
                       want[f*ACC_W +: ACC_W], m_axis_tdata[f*ACC_W +: ACC_W]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    setting_e kind;

    // directed cells under the reset settings
    add_row(0, 0, 0, CRN_ZERO, 1'b1, 1'b1, whole_totals(0, 0, 0, 0));
    add_row(0, 0, 0, CRN_ALL_NEG1, 1'b1, 1'b1, whole_totals(1000, 500, 500, -250));
    add_row(5, 3, 7, CRN_ONE_NEG1, 1'b0, 1'b0, '0);
    add_row(1022, 1022, 1022, CRN_ALL_MIN, 1'b0, 1'b0, '0);
    add_row(1023, 0, 0, CRN_ALL_NEG1, 1'b0, 1'b0, '0);
    add_row(0, 1023, 0, CRN_ALL_NEG1, 1'b0, 1'b0, '0);
    add_row(0, 0, 1023, CRN_ALL_NEG1, 1'b1, 1'b0, '0);
    // out of grid, nothing summed since the clear
    add_row(1023, 1023, 1023, CRN_ALL_NEG1, 1'b1, 1'b1, whole_totals(0, 0, 0, 0));
    // corner sums at the solid boundary
    add_row(2, 2, 2, CRN_ZERO_MIX, 1'b0, 1'b0, '0);
    add_row(4, 4, 4, CRN_ONE_POS1, 1'b0, 1'b0, '0);
    add_row(9, 9, 9, CRN_ALL_MAX, 1'b0, 1'b0, '0);
    add_row(8, 8, 8, CRN_SEVEN_MAX, 1'b0, 1'b0, '0);
    add_row(1, 1, 1, CRN_HALF_MIX, 1'b1, 1'b1, whole_totals(1000, 1500, 4500, -2250));
    add_row(1022, 0, 1022, CRN_HALF_MIX, 1'b0, 1'b0, '0);
    add_row(0, 1022, 0, CRN_ALL_NEG1, 1'b0, 1'b0, '0);
    add_row(511, 682, 341, CRN_SCATTER, 1'b0, 1'b0, '0);
    add_row(341, 511, 682, CRN_ONE_NEG1, 1'b1, 1'b0, '0);
    add_row(1022, 1022, 1022, CRN_ALL_MIN, 1'b1, 1'b0, '0);
    add_row(1022, 511, 0, CRN_ALL_MIN, 1'b0, 1'b0, '0);
    add_row(0, 1022, 511, CRN_ALL_NEG1, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cell_table[r]) begin
      send_cell(cell_table[r].beat, cell_table[r].last, draw_gap());
      if (cell_table[r].typed) pending_totals[pending_totals.size() - 1] = cell_table[r].totals;
    end
    settle();

    // random runs under a sequence of register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      kind = setting_e'(p % NUM_SETTINGS);
      apply_setting(pick_setting(kind));
      run_phase(CELLS_PER_SETTING);
      settle();
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/vmm_pkg.sv
hdl/vmm_fifo.sv
hdl/vmm_front.sv
hdl/vmm_mul.sv
hdl/vmm_back.sv
hdl/voxel_mass_moment_accumulator_core.sv
bench/tb_voxel_mass_moment_accumulator_core.sv
